// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the bitmap to braille cell converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds on every clock edge outside reset.
`define B2BC_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Checks that a condition is followed by another one on the next edge.
`define B2BC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/b2bc_pkg.sv =====
// Shared types, constants and functions of the bitmap to braille cell converter.
package b2bc_pkg;

  localparam int MAX_ROW_BYTES_DEF = 64;

  localparam int WIDTH_W = 10;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W = 12;
  localparam int PIX_W = 8;
  localparam int CODE_W = 14;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CELLS_PER_BYTE = 4;
  localparam int CELL_W = 8;
  localparam int WORD_W = CELLS_PER_BYTE * CELL_W;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PIXELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_ROWS = 2'd1;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 10'd512;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;
  localparam logic [CODE_W-1:0] CELL_BASE = 14'h2800;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CELLS_PER_BYTE-1:0] line_end;
    logic last_row;
    logic [1:0] last_idx;
  } emit_load_t;

  function automatic logic [CELL_W-1:0] pair_dots(input logic [1:0] band_row,
                                                  input logic [1:0] pair);
    logic [CELL_W-1:0] d;
    d = '0;
    if (band_row == 2'd3) begin
      d[6] = pair[0];
      d[7] = pair[1];
    end else begin
      d[band_row] = pair[0];
      d[3'(band_row) + 3'd3] = pair[1];
    end
    return d;
  endfunction

endpackage

// ===== hdl/b2bc_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
module b2bc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/b2bc_lane.sv =====
// One cell lane: merges the dots of one pixel pair into its cell pattern.
module b2bc_lane (
  input  logic [1:0] band_row,
  input  logic [1:0] pair,
  input  logic       active,
  input  logic [7:0] old_cell,
  output logic [7:0] new_cell
);
  import b2bc_pkg::*;

  always_comb begin
    new_cell = old_cell;
    if (active) begin
      new_cell = old_cell | pair_dots(band_row, pair);
    end
  end

endmodule

// ===== hdl/b2bc_emit.sv =====
// Output stage that sends the finished cells of one byte one cell at a time.
`include "assert_macros.svh"

module b2bc_emit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load_valid,
  input  b2bc_pkg::emit_load_t                  load,
  output logic                                  can_load,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [b2bc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // cell_code
  output logic                                  m_axis_tlast,  // last_in_line
  output logic [b2bc_pkg::OUT_USER_W-1:0]       m_axis_tuser   // last_of_byte, last_in_image
);
  import b2bc_pkg::*;

  logic                      valid;
  logic [1:0]                idx;
  emit_load_t                held;
  logic [CELL_W-1:0]         cell_bits;
  logic                      at_last;

  assign at_last = (idx == held.last_idx);
  assign can_load = !valid || (m_axis_tready && at_last);
  assign cell_bits = held.word[{idx, 3'b000} +: CELL_W];

  assign m_axis_tvalid = valid;
  assign m_axis_tdata = {{(OUT_DATA_W - CODE_W){1'b0}}, CELL_BASE + CODE_W'(cell_bits)};
  assign m_axis_tlast = held.line_end[idx];
  assign m_axis_tuser = {held.line_end[idx] & held.last_row, at_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx <= '0;
    end else if (load_valid && can_load) begin
      valid <= 1'b1;
      idx <= '0;
    end else if (valid && m_axis_tready) begin
      if (at_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && can_load) begin
      held <= load;
    end
  end

  `B2BC_ASSERT(a_idx_in_range, !valid || (idx <= held.last_idx))
  `B2BC_ASSERT(a_line_end_closes_byte, !(valid && held.line_end[idx]) || at_last)

endmodule

// ===== hdl/bitmap_to_braille_cells.sv =====
// Top level of the bitmap to braille cell converter.
// Pixel bytes arrive row by row; each byte is one column of the line store, and four lanes fold
// its four pixel pairs into the stored cell patterns, a read-modify-write of one 32-bit word
// per byte with a forward path so a byte may follow the previous one in the next cycle. Bytes
// of rows that close no band are taken at one per cycle. Bytes of the fourth row of a band,
// or of the image's last row, send up to four cells each over the one-word output, one cell
// per transfer, and leave the first stage only when the output stage can load them. The first
// cell of a byte is presented once the byte has passed the first-stage registers and been
// loaded into the output stage's holding register. Writing either configuration register
// restarts the image at its first row and column; the line store needs no clearing after
// reset, since every band rewrites each column on its first row.
`include "assert_macros.svh"

module bitmap_to_braille_cells #(
  parameter int MAX_ROW_BYTES = b2bc_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [b2bc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [b2bc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [b2bc_pkg::PIX_W-1:0]       s_axis_tdata,  // pixel_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [b2bc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // cell_code
  output logic                             m_axis_tlast,  // last_in_line
  output logic [b2bc_pkg::OUT_USER_W-1:0]  m_axis_tuser   // last_of_byte, last_in_image
);
  import b2bc_pkg::*;

  localparam int ColW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int MaxPix = MAX_ROW_BYTES * 8;
  localparam logic [WIDTH_W-1:0] WidthCap = (MaxPix > 1023) ? '1 : WIDTH_W'(MaxPix);

  logic [WIDTH_W-1:0]  width_pixels;
  logic [HEIGHT_W-1:0] height_rows;
  logic [ColW-1:0]     byte_column;
  logic [ROW_W-1:0]    pixel_row;

  logic [WIDTH_W-1:0]  width_nz;
  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [7:0]          row_bytes;
  logic [9:0]          cells;
  logic [ColW-1:0]     col_eff;
  logic                last_row;
  logic                emit_row;
  logic                row_wrap;
  logic [CELLS_PER_BYTE-1:0] act;
  logic [CELLS_PER_BYTE-1:0] lend;
  logic [12:0]         cell_idx [CELLS_PER_BYTE];

  logic                in_accept;
  logic                cfg_hit;

  logic                s1_valid;
  logic [ColW-1:0]     s1_col;
  logic [1:0]          s1_row;
  logic [PIX_W-1:0]    s1_pix;
  logic [CELLS_PER_BYTE-1:0] s1_act;
  logic [CELLS_PER_BYTE-1:0] s1_lend;
  logic                s1_last_row;
  logic                s1_emit;
  logic                s1_move;

  logic [WORD_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]   old_word;
  logic [WORD_W-1:0]   new_word;
  logic                last_valid;
  logic [ColW-1:0]     last_col;
  logic [WORD_W-1:0]   last_word;

  emit_load_t          load;
  logic                can_load;

  assign width_nz = (width_pixels == '0) ? WIDTH_W'(1) : width_pixels;
  assign eff_w = (width_nz > WidthCap) ? WidthCap : width_nz;

  always_comb begin
    eff_h = height_rows;
    if (height_rows == '0) begin
      eff_h = HEIGHT_W'(1);
    end else if (height_rows > HEIGHT_MAX) begin
      eff_h = HEIGHT_MAX;
    end
  end

  assign row_bytes = 8'((11'(eff_w) + 11'd7) >> 3);
  assign cells = 10'((11'(eff_w) + 11'd1) >> 1);
  assign col_eff = (12'(byte_column) >= 12'(row_bytes)) ?
                   ColW'(row_bytes - 8'd1) : byte_column;
  assign last_row = (13'(pixel_row) >= (eff_h - 13'd1));
  assign emit_row = (pixel_row[1:0] == 2'd3) || last_row;
  assign row_wrap = (12'(col_eff) + 12'd1 >= 12'(row_bytes));

  always_comb begin
    for (int k = 0; k < CELLS_PER_BYTE; k++) begin
      cell_idx[k] = (13'(col_eff) << 2) + 13'(k);
      act[k] = (cell_idx[k] < 13'(cells));
      lend[k] = (cell_idx[k] + 13'd1 == 13'(cells));
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg_hit = cfg_valid && ((cfg_index == REG_WIDTH_PIXELS) ||
                                 (cfg_index == REG_HEIGHT_ROWS));

  assign s1_move = s1_valid && (!s1_emit || can_load);
  assign s_axis_tready = !s1_valid || s1_move;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_pixels <= WIDTH_RESET;
      height_rows <= HEIGHT_RESET;
      byte_column <= '0;
      pixel_row <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        REG_WIDTH_PIXELS: width_pixels <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT_ROWS: height_rows <= cfg_data;
        default: ;
      endcase
      byte_column <= '0;
      pixel_row <= '0;
    end else if (in_accept) begin
      if (row_wrap) begin
        byte_column <= '0;
        pixel_row <= last_row ? '0 : pixel_row + ROW_W'(1);
      end else begin
        byte_column <= col_eff + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col <= col_eff;
      s1_row <= pixel_row[1:0];
      s1_pix <= s_axis_tdata;
      s1_act <= act;
      s1_lend <= lend;
      s1_last_row <= last_row;
      s1_emit <= emit_row;
    end
  end

  b2bc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_ROW_BYTES)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (s1_move),
    .wr_addr(s1_col),
    .wr_data(new_word),
    .rd_en  (in_accept),
    .rd_addr(col_eff),
    .rd_data(ram_rdata)
  );

  always_comb begin
    old_word = ram_rdata;
    if (s1_row == 2'd0) begin
      old_word = '0;
    end else if (last_valid && (last_col == s1_col)) begin
      old_word = last_word;
    end
  end

  for (genvar k = 0; k < CELLS_PER_BYTE; k++) begin : g_lane
    b2bc_lane u_lane (
      .band_row(s1_row),
      .pair    (s1_pix[2*k +: 2]),
      .active  (s1_act[k]),
      .old_cell(old_word[CELL_W*k +: CELL_W]),
      .new_cell(new_word[CELL_W*k +: CELL_W])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else if (s1_move) begin
      last_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      last_col <= s1_col;
      last_word <= new_word;
    end
  end

  always_comb begin
    load.word = new_word;
    load.line_end = s1_lend;
    load.last_row = s1_last_row;
    if (s1_act[3]) begin
      load.last_idx = 2'd3;
    end else if (s1_act[2]) begin
      load.last_idx = 2'd2;
    end else if (s1_act[1]) begin
      load.last_idx = 2'd1;
    end else begin
      load.last_idx = 2'd0;
    end
  end

  b2bc_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (s1_move && s1_emit),
    .load         (load),
    .can_load     (can_load),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  `B2BC_ASSERT(a_row_in_image, 13'(pixel_row) <= (eff_h - 13'd1))
  `B2BC_ASSERT(a_col_in_row, 12'(byte_column) < 12'(row_bytes))
  `B2BC_ASSERT_NEXT(a_stall_holds_byte, s1_valid && !s1_move, s1_valid)

endmodule
